>>> rtl/core/ewq_pkg.sv
// ----------------------------------------------------------------------------
// Event wait queue package
// Shared command and action codes, item types and the queue entry type.
// ----------------------------------------------------------------------------
package ewq_pkg;

	// Command codes of an input item.
	localparam logic [1:0] CMD_WAIT     = 2'd0;
	localparam logic [1:0] CMD_WAKE_ALL = 2'd1;
	localparam logic [1:0] CMD_WAKE_ONE = 2'd2;
	localparam logic [1:0] CMD_REMOVE   = 2'd3;

	// Action codes of a result item.
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_BLOCK   = 2'd1;
	localparam logic [1:0] ACT_UNBLOCK = 2'd2;
	localparam logic [1:0] ACT_RANGE   = 2'd3;

	// Depth of the queue between front and back.
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [4:0]  thread_id;
		logic [4:0]  event_id;
		logic [31:0] object_tag;
	} ewq_req_t;

	typedef struct packed {
		logic [1:0] action;
		logic [4:0] thread_out;
		logic       found;
		logic       last;
	} ewq_rsp_t;

	// Operation chosen by the front for the back to carry out.
	typedef enum logic [2:0] {
		OP_WAIT,
		OP_WAKE_ALL,
		OP_WAKE_ONE,
		OP_REMOVE,
		OP_REJECT
	} ewq_op_t;

	typedef struct packed {
		ewq_op_t     op;
		logic [1:0]  rej_action;
		logic [4:0]  thread_id;
		logic [4:0]  event_id;
		logic [31:0] object_tag;
	} ewq_entry_t;

endpackage

>>> rtl/core/ewq_front.sv
// ----------------------------------------------------------------------------
// Event wait queue front
// Checks the ranges of an incoming item and turns it into a queue entry.
// ----------------------------------------------------------------------------
module ewq_front import ewq_pkg::*; #(
	parameter int NUM_THREADS = 32,
	parameter int NUM_EVENTS  = 18
) (
	input  logic       req_valid,
	input  ewq_req_t   req,
	output logic       push,
	output ewq_entry_t entry
);

	logic ev_ok;
	logic ev_high;
	logic t_ok;

	// Range checks on the thread and event of the item.
	assign ev_ok   = (req.event_id != 5'd0) && (32'(req.event_id) <= NUM_EVENTS);
	assign ev_high = 32'(req.event_id) > NUM_EVENTS;
	assign t_ok    = 32'(req.thread_id) < NUM_THREADS;
	assign push    = req_valid;

	// Classify the item; anything rejected carries its result with it.
	always_comb begin
		entry.rej_action = ACT_NONE;
		entry.thread_id  = req.thread_id;
		entry.event_id   = req.event_id;
		entry.object_tag = req.object_tag;
		entry.op         = OP_REJECT;
		if (req.cmd == CMD_WAKE_ALL) begin
			if (ev_ok) begin
				entry.op = OP_WAKE_ALL;
			end else begin
				entry.rej_action = ACT_RANGE;
				entry.thread_id  = 5'd0;
			end
		end else if (!t_ok) begin
			entry.rej_action = (req.cmd == CMD_WAKE_ONE && !ev_ok) ? ACT_RANGE : ACT_NONE;
		end else begin
			unique case (req.cmd)
				CMD_WAIT: begin
					if (ev_high) entry.rej_action = ACT_RANGE;
					else entry.op = OP_WAIT;
				end
				CMD_WAKE_ONE: begin
					if (!ev_ok) entry.rej_action = ACT_RANGE;
					else entry.op = OP_WAKE_ONE;
				end
				default: begin
					entry.op = OP_REMOVE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/ewq_queue.sv
// ----------------------------------------------------------------------------
// Event wait queue entry FIFO
// Short queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module ewq_queue import ewq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ewq_entry_t push_entry,
	output logic       full,
	output logic       pop_valid,
	output ewq_entry_t pop_entry,
	input  logic       pop
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	ewq_entry_t     slot_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full      = count_q == CW'(QDEPTH);
	assign pop_valid = count_q != '0;
	assign pop_entry = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/core/ewq_back.sv
// ----------------------------------------------------------------------------
// Event wait queue back end
// Sequencer that keeps the per-event thread lists and produces results.
// ----------------------------------------------------------------------------
module ewq_back import ewq_pkg::*; #(
	parameter int NUM_THREADS = 32,
	parameter int NUM_EVENTS  = 18,
	parameter int TAG_BITS    = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  ewq_entry_t q_entry,
	output logic       q_pop,
	output logic       rsp_valid,
	output ewq_rsp_t   rsp,
	input  logic       rsp_stall
);

	localparam int TIW = $clog2(NUM_THREADS);
	localparam int LW  = $clog2(NUM_THREADS + 1);
	localparam int EW  = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
	localparam int TW  = (TAG_BITS < 32) ? TAG_BITS : 32;
	localparam logic [LW-1:0] NIL = LW'(NUM_THREADS);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_AP1, S_AP2, S_FIN} state_t;

	state_t         state_q;
	ewq_op_t        op_q;
	logic [4:0]     tid_q;
	logic [4:0]     ev_q;
	logic [EW-1:0]  e_q;
	logic [TW-1:0]  tag_q;
	logic [LW-1:0]  cur_q;
	logic           pend_v_q;
	logic [4:0]     pend_thr_q;
	ewq_rsp_t       res_q;
	logic           out_v_q;
	ewq_rsp_t       out_q;

	// Per-thread memories and their registered read data.
	logic [4:0]     ev_mem  [NUM_THREADS];
	logic [TW-1:0]  obj_mem [NUM_THREADS];
	logic [LW-1:0]  nxt_mem [NUM_THREADS];
	logic [LW-1:0]  prv_mem [NUM_THREADS];
	logic           vld_q   [NUM_THREADS];
	logic [4:0]     ev_rd_q;
	logic [TW-1:0]  obj_rd_q;
	logic [LW-1:0]  nxt_rd_q;
	logic [LW-1:0]  prv_rd_q;

	// Per-event list ends.
	logic [LW-1:0]  head_q [NUM_EVENTS];
	logic [LW-1:0]  tail_q [NUM_EVENTS];

	logic [TIW-1:0] rd_idx;
	logic [TIW-1:0] t_idx;
	logic [EW-1:0]  q_e;
	logic [EW-1:0]  ev_d_e;
	logic [LW-1:0]  tail_e;
	logic           out_free;
	logic           out_set;
	logic           match;
	logic           walk_hold;
	logic           unl_req;
	logic           unl;
	logic           ap1;
	logic           ap2;

	logic           nxt_we;
	logic [TIW-1:0] nxt_wa;
	logic [LW-1:0]  nxt_wd;
	logic           prv_we;
	logic [TIW-1:0] prv_wa;
	logic [LW-1:0]  prv_wd;
	logic           head_we;
	logic [EW-1:0]  head_wa;
	logic [LW-1:0]  head_wd;
	logic           tail_we;
	logic [EW-1:0]  tail_wa;
	logic [LW-1:0]  tail_wd;

	assign rd_idx    = cur_q[TIW-1:0];
	assign t_idx     = TIW'(tid_q);
	assign q_e       = EW'(q_entry.event_id - 5'd1);
	assign ev_d_e    = EW'(ev_rd_q - 5'd1);
	assign tail_e    = tail_q[e_q];
	assign out_free  = !out_v_q || !rsp_stall;
	assign match     = (obj_rd_q == '0) || (obj_rd_q == tag_q);
	assign walk_hold = (op_q == OP_WAKE_ALL) && match && pend_v_q && !out_free;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	// The output register is loaded at the end of an item or when a walk releases
	// a held-back wakeup.
	assign out_set = ((state_q == S_FIN) && out_free) ||
		((state_q == S_CHK) && (op_q == OP_WAKE_ALL) && !walk_hold && match && pend_v_q);

	// Decide whether the thread just read is taken off its list.
	always_comb begin
		case (op_q) inside
			OP_WAIT, OP_REMOVE: unl_req = 1'b1;
			OP_WAKE_ONE:        unl_req = ev_rd_q == ev_q;
			OP_WAKE_ALL:        unl_req = match && !walk_hold;
			default:            unl_req = 1'b0;
		endcase
	end

	assign unl = (state_q == S_CHK) && unl_req && (ev_rd_q != 5'd0);
	assign ap1 = (state_q == S_AP1) && (ev_q != 5'd0);
	assign ap2 = state_q == S_AP2;

	// Link write ports: unlink fixes the neighbours, append joins the tail.
	always_comb begin
		nxt_we  = 1'b0;
		nxt_wa  = prv_rd_q[TIW-1:0];
		nxt_wd  = nxt_rd_q;
		prv_we  = 1'b0;
		prv_wa  = nxt_rd_q[TIW-1:0];
		prv_wd  = prv_rd_q;
		head_we = 1'b0;
		head_wa = ev_d_e;
		head_wd = nxt_rd_q;
		tail_we = 1'b0;
		tail_wa = ev_d_e;
		tail_wd = prv_rd_q;
		if (unl) begin
			nxt_we  = prv_rd_q != NIL;
			head_we = prv_rd_q == NIL;
			prv_we  = nxt_rd_q != NIL;
			tail_we = nxt_rd_q == NIL;
		end else if (ap1) begin
			nxt_we = 1'b1;
			nxt_wa = t_idx;
			nxt_wd = NIL;
			prv_we = 1'b1;
			prv_wa = t_idx;
			prv_wd = tail_e;
		end else if (ap2) begin
			nxt_we  = tail_e != NIL;
			nxt_wa  = tail_e[TIW-1:0];
			nxt_wd  = LW'(tid_q);
			head_we = tail_e == NIL;
			head_wa = e_q;
			head_wd = LW'(tid_q);
			tail_we = 1'b1;
			tail_wa = e_q;
			tail_wd = LW'(tid_q);
		end
	end

	// Per-thread memories, one write and one registered read each.
	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (ap1) begin
			ev_mem[t_idx]  <= ev_q;
			obj_mem[t_idx] <= tag_q;
		end
		nxt_rd_q <= nxt_mem[rd_idx];
		prv_rd_q <= prv_mem[rd_idx];
		obj_rd_q <= obj_mem[rd_idx];
		ev_rd_q  <= vld_q[rd_idx] ? ev_mem[rd_idx] : 5'd0;
	end

	// Waiting flags: a thread not flagged waits on no event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_THREADS; i++) vld_q[i] <= 1'b0;
		end else begin
			if (unl) vld_q[rd_idx] <= 1'b0;
			if (ap1) vld_q[t_idx] <= 1'b1;
		end
	end

	// List heads and tails.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_EVENTS; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
		end else begin
			if (head_we) head_q[head_wa] <= head_wd;
			if (tail_we) tail_q[tail_wa] <= tail_wd;
		end
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_REJECT;
			tid_q      <= '0;
			ev_q       <= '0;
			e_q        <= '0;
			tag_q      <= '0;
			cur_q      <= '0;
			pend_v_q   <= 1'b0;
			pend_thr_q <= '0;
			res_q      <= '0;
			out_v_q    <= 1'b0;
			out_q      <= '0;
		end else begin
			out_v_q <= out_set || (out_v_q && rsp_stall);
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						op_q     <= q_entry.op;
						tid_q    <= q_entry.thread_id;
						ev_q     <= q_entry.event_id;
						e_q      <= q_e;
						tag_q    <= TW'(q_entry.object_tag);
						pend_v_q <= 1'b0;
						if (q_entry.op == OP_REJECT) begin
							res_q   <= '{q_entry.rej_action, q_entry.thread_id, 1'b0, 1'b1};
							state_q <= S_FIN;
						end else if (q_entry.op == OP_WAKE_ALL) begin
							if (head_q[q_e] == NIL) begin
								res_q   <= '{ACT_NONE, 5'd0, 1'b0, 1'b1};
								state_q <= S_FIN;
							end else begin
								cur_q   <= head_q[q_e];
								state_q <= S_RD;
							end
						end else begin
							cur_q   <= LW'(q_entry.thread_id);
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					unique case (op_q)
						OP_WAIT: begin
							state_q <= S_AP1;
						end
						OP_REMOVE: begin
							res_q   <= '{ACT_NONE, tid_q, 1'b0, 1'b1};
							state_q <= S_FIN;
						end
						OP_WAKE_ONE: begin
							if (ev_rd_q == ev_q) res_q <= '{ACT_UNBLOCK, tid_q, 1'b1, 1'b1};
							else res_q <= '{ACT_NONE, tid_q, 1'b0, 1'b1};
							state_q <= S_FIN;
						end
						OP_WAKE_ALL: begin
							if (!walk_hold) begin
								// A new match releases the one held back, not yet last.
								if (match) begin
									if (pend_v_q) begin
										out_q <= '{ACT_UNBLOCK, pend_thr_q, 1'b0, 1'b0};
									end
									pend_v_q   <= 1'b1;
									pend_thr_q <= 5'(cur_q);
								end
								cur_q <= nxt_rd_q;
								if (nxt_rd_q == NIL) begin
									if (match) res_q <= '{ACT_UNBLOCK, 5'(cur_q), 1'b0, 1'b1};
									else if (pend_v_q) res_q <= '{ACT_UNBLOCK, pend_thr_q, 1'b0, 1'b1};
									else res_q <= '{ACT_NONE, 5'd0, 1'b0, 1'b1};
									state_q <= S_FIN;
								end else begin
									state_q <= S_RD;
								end
							end
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_AP1: begin
					res_q <= '{ACT_BLOCK, tid_q, 1'b0, 1'b1};
					state_q <= (ev_q == 5'd0) ? S_FIN : S_AP2;
				end
				S_AP2: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/event_wait_queue_unit_core.sv
// ----------------------------------------------------------------------------
// Event wait queue unit
// Per-event FIFO lists of waiting threads with wait, wake and remove.
// ----------------------------------------------------------------------------
//  Channel | Handshake                 | Payload
//  req     | req_valid / req_stall     | ewq_req_t: cmd, thread_id, event_id, object_tag
//  rsp     | rsp_valid / rsp_stall     | ewq_rsp_t: action, thread_out, found, last
//
// A wake-all walks the list of its event from the head; each step reads the
// link memories through their single registered read port.
// Reset clears the list ends and waiting flags at once; no clearing pass is run.
// A two-entry queue lets items arrive while the sequencer or the output stalls.
// ----------------------------------------------------------------------------
module event_wait_queue_unit_core import ewq_pkg::*; #(
	parameter int NUM_THREADS = 32,
	parameter int NUM_EVENTS  = 18,
	parameter int TAG_BITS    = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  ewq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ewq_rsp_t rsp
);

	logic       push;
	ewq_entry_t push_entry;
	logic       full;
	logic       q_valid;
	ewq_entry_t q_entry;
	logic       q_pop;

	assign req_stall = full;

	ewq_front #(
		.NUM_THREADS(NUM_THREADS),
		.NUM_EVENTS (NUM_EVENTS)
	) u_front (
		.req_valid(req_valid),
		.req      (req),
		.push     (push),
		.entry    (push_entry)
	);

	ewq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop_valid (q_valid),
		.pop_entry (q_entry),
		.pop       (q_pop)
	);

	ewq_back #(
		.NUM_THREADS(NUM_THREADS),
		.NUM_EVENTS (NUM_EVENTS),
		.TAG_BITS   (TAG_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.rsp_stall(rsp_stall)
	);

	// A found flag only ever comes with a final unblock.
	a_found_unblock: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.action == ACT_UNBLOCK && rsp.last)
		else $error("found set on a result that is not a final unblock");

	// Block, range and no-op results close their item.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.action != ACT_UNBLOCK |-> rsp.last)
		else $error("non-unblock result without last");

	// The queue is popped only when it holds an entry.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule
